FILE: hw/rtl/kea_pkg.sv
// ----------------------------------------------------------------------------
// kea_pkg
// Shared types, constants, keymap ROM and helpers for the keyboard event
// autorepeat block.
// ----------------------------------------------------------------------------
package kea_pkg;

  localparam int KEY_W       = 64;
  localparam int KEY_COUNT   = 64;
  localparam int IDX_W       = 6;
  localparam int EV_W        = 8;
  localparam int DELAY_W     = 10;
  localparam int CFG_IDX_W   = 1;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_COUNT);
  localparam logic [DELAY_W-1:0] TICK_MAX = {DELAY_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_DELAY  = 1'd1;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 10'd20;
  localparam logic [DELAY_W-1:0] NEXT_DELAY_RST  = 10'd5;

  // event codes with special handling
  localparam logic [EV_W-1:0] EV_NONE      = 8'd0;
  localparam logic [EV_W-1:0] EV_BACKSPACE = 8'd2;
  localparam logic [EV_W-1:0] EV_RIGHT     = 8'd10;
  localparam logic [EV_W-1:0] EV_UP        = 8'd21;
  localparam logic [EV_W-1:0] EV_DOWN      = 8'd26;
  localparam logic [EV_W-1:0] EV_LEFT      = 8'd35;
  localparam logic [EV_W-1:0] EV_LPAREN    = 8'd38;
  localparam logic [EV_W-1:0] EV_LBRACKET  = 8'd45;
  localparam logic [EV_W-1:0] EV_LBRACE    = 8'd50;
  localparam logic [EV_W-1:0] EV_RPAREN    = 8'd111;
  localparam logic [EV_W-1:0] EV_RBRACE    = 8'd112;
  localparam logic [EV_W-1:0] EV_RBRACKET  = 8'd113;

  typedef struct packed {
    logic [EV_W-1:0]  event_code;
    logic [IDX_W-1:0] key_index;
    logic             from_repeat;
    logic             last;
  } result_t;

  // row select: bit 0 shift, bit 1 alpha
  localparam logic [EV_W-1:0] KEYMAP [4][64] = '{
    '{8'd0,8'd1,8'd2,8'd0,8'd0,8'd3,8'd4,8'd5, 8'd0,8'd6,8'd7,8'd8,8'd0,8'd0,8'd9,8'd10,
      8'd0,8'd11,8'd0,8'd12,8'd0,8'd0,8'd13,8'd0, 8'd0,8'd14,8'd15,8'd16,8'd17,8'd0,8'd18,8'd0,
      8'd0,8'd19,8'd0,8'd20,8'd0,8'd21,8'd22,8'd0, 8'd0,8'd23,8'd24,8'd25,8'd26,8'd27,8'd28,8'd0,
      8'd0,8'd29,8'd30,8'd31,8'd32,8'd33,8'd34,8'd0, 8'd0,8'd35,8'd36,8'd37,8'd38,8'd0,8'd39,8'd0},
    '{8'd0,8'd40,8'd41,8'd0,8'd0,8'd42,8'd43,8'd5, 8'd0,8'd0,8'd0,8'd44,8'd0,8'd0,8'd45,8'd10,
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0, 8'd0,8'd0,8'd15,8'd46,8'd17,8'd0,8'd47,8'd0,
      8'd0,8'd0,8'd48,8'd49,8'd0,8'd21,8'd50,8'd0, 8'd0,8'd51,8'd0,8'd52,8'd26,8'd0,8'd0,8'd0,
      8'd0,8'd53,8'd54,8'd31,8'd32,8'd55,8'd0,8'd0, 8'd0,8'd35,8'd0,8'd0,8'd0,8'd0,8'd56,8'd0},
    '{8'd0,8'd57,8'd2,8'd58,8'd0,8'd59,8'd60,8'd5, 8'd0,8'd48,8'd61,8'd62,8'd0,8'd0,8'd63,8'd10,
      8'd0,8'd64,8'd65,8'd66,8'd0,8'd0,8'd67,8'd0, 8'd0,8'd68,8'd15,8'd69,8'd17,8'd0,8'd70,8'd0,
      8'd0,8'd71,8'd72,8'd73,8'd0,8'd21,8'd74,8'd0, 8'd0,8'd75,8'd76,8'd77,8'd26,8'd78,8'd79,8'd0,
      8'd0,8'd0,8'd80,8'd31,8'd32,8'd33,8'd0,8'd0, 8'd0,8'd35,8'd81,8'd82,8'd83,8'd0,8'd84,8'd0},
    '{8'd0,8'd85,8'd2,8'd86,8'd0,8'd87,8'd88,8'd5, 8'd0,8'd48,8'd89,8'd90,8'd0,8'd0,8'd91,8'd10,
      8'd0,8'd92,8'd93,8'd94,8'd0,8'd0,8'd95,8'd0, 8'd0,8'd96,8'd15,8'd97,8'd17,8'd0,8'd98,8'd0,
      8'd0,8'd71,8'd99,8'd100,8'd0,8'd21,8'd101,8'd0, 8'd0,8'd75,8'd102,8'd103,8'd26,8'd104,8'd105,8'd0,
      8'd0,8'd53,8'd106,8'd31,8'd32,8'd55,8'd0,8'd0, 8'd0,8'd35,8'd107,8'd108,8'd109,8'd0,8'd110,8'd0}
  };

  // arrows and backspace auto-repeat
  function automatic logic repeatable(input logic [EV_W-1:0] ev);
    return (ev == EV_LEFT) || (ev == EV_UP) || (ev == EV_DOWN) ||
           (ev == EV_RIGHT) || (ev == EV_BACKSPACE);
  endfunction

  // closing partner of an opening bracket, EV_NONE otherwise
  function automatic logic [EV_W-1:0] partner_of(input logic [EV_W-1:0] ev);
    logic [EV_W-1:0] p;
    p = EV_NONE;
    if (ev == EV_LPAREN)   p = EV_RPAREN;
    if (ev == EV_LBRACE)   p = EV_RBRACE;
    if (ev == EV_LBRACKET) p = EV_RBRACKET;
    return p;
  endfunction

  // index of the lowest set bit; isolate it, then encode the one-hot word
  function automatic logic [IDX_W-1:0] lowest_index(input logic [KEY_W-1:0] v);
    logic [KEY_W-1:0] onehot;
    logic [IDX_W-1:0] idx;
    onehot = v & (~v + {{(KEY_W-1){1'b0}}, 1'b1});
    idx    = '0;
    for (int k = 0; k < KEY_W; k++) begin
      if (onehot[k]) idx = idx | IDX_W'(k);
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/keyboard_event_autorepeat.sv
// ----------------------------------------------------------------------------
// keyboard_event_autorepeat
// Key matrix scan decoder with keymap lookup, closing-bracket stacking and
// typematic repeat of arrows and backspace.
// ----------------------------------------------------------------------------
// One request per scan tick carries the 64-bit key word and the shift/alpha
// flags. The request is taken into an input register and processed from it:
// the lowest key that went from up to down is found, looked up in the
// 4x64 keymap ROM, and the resulting event (plus a closing partner for a left
// parenthesis, brace or bracket) is pushed into a four-entry result queue.
// With no fresh event, an arrow or backspace held with the key word unchanged
// repeats after first_repeat_delay ticks and then every next_repeat_delay
// ticks. A new request is accepted every cycle while the queue holds at most
// two results, so ticks stream at one per cycle; ticks producing two results
// are limited by the output side draining one result per cycle. The tick
// counter saturates at 1023. Configuration is written through cfg_write /
// cfg_index / cfg_data, by the user, while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module keyboard_event_autorepeat (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [kea_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kea_pkg::DELAY_W-1:0]         cfg_data,
  // scan tick requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kea_pkg::KEY_W-1:0]           key_state,
  input  logic                                shift_active,
  input  logic                                alpha_active,
  // event results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [kea_pkg::EV_W-1:0]            event_code,
  output logic [kea_pkg::IDX_W-1:0]           key_index,
  output logic                                from_repeat,
  output logic                                last
);

  // configuration registers
  logic [kea_pkg::DELAY_W-1:0] first_repeat_delay;
  logic [kea_pkg::DELAY_W-1:0] next_repeat_delay;

  // input register
  logic                        s1_valid;
  logic [kea_pkg::KEY_W-1:0]   s1_key;
  logic [1:0]                  s1_sel;

  // scan state
  logic [kea_pkg::KEY_W-1:0]   seen_up_mask, seen_up_mask_next;
  logic [kea_pkg::DELAY_W-1:0] ticks_waited, ticks_waited_next;
  logic [kea_pkg::EV_W-1:0]    held_event, held_event_next;
  logic [kea_pkg::IDX_W-1:0]   held_key_index, held_key_index_next;
  logic [kea_pkg::KEY_W-1:0]   held_key_state, held_key_state_next;
  logic                        repeat_running, repeat_running_next;

  // result queue
  kea_pkg::result_t            fifo [4];
  logic [1:0]                  wr_ptr, rd_ptr;
  logic [2:0]                  count;

  // processing signals
  logic                        fire, pop;
  logic [kea_pkg::KEY_W-1:0]   ks, seen, fresh;
  logic [kea_pkg::IDX_W-1:0]   idx;
  logic [kea_pkg::EV_W-1:0]    ev, partner;
  logic [kea_pkg::DELAY_W-1:0] ticks_inc, delay;
  logic                        rr_cur, do_repeat;
  logic [1:0]                  push_n;
  kea_pkg::result_t            res0, res1;

  // a tick is processed only when the queue has room for two results
  assign fire     = s1_valid && (count <= 3'd2);
  assign in_ready = !s1_valid || fire;
  assign pop      = out_valid && out_ready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      first_repeat_delay <= kea_pkg::FIRST_DELAY_RST;
      next_repeat_delay  <= kea_pkg::NEXT_DELAY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        kea_pkg::REG_FIRST_DELAY: first_repeat_delay <= cfg_data;
        kea_pkg::REG_NEXT_DELAY:  next_repeat_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input reg
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key <= key_state;
      s1_sel <= {alpha_active, shift_active};
    end
  end

  // ---------------------------------------------------------------- tick logic
  always_comb begin
    ks        = s1_key & kea_pkg::KEY_MASK;
    seen      = (seen_up_mask | ~ks) & kea_pkg::KEY_MASK;
    fresh     = seen & ks;
    idx       = kea_pkg::lowest_index(fresh);
    ev        = kea_pkg::KEYMAP[s1_sel][idx];
    partner   = kea_pkg::partner_of(ev);
    ticks_inc = (ticks_waited == kea_pkg::TICK_MAX) ? ticks_waited
                                                    : ticks_waited + 1'b1;
    // any fresh key, mapped or not, stops the repeat run
    rr_cur    = (fresh != '0) ? 1'b0 : repeat_running;
    delay     = rr_cur ? next_repeat_delay : first_repeat_delay;
    do_repeat = kea_pkg::repeatable(held_event) && (ks == held_key_state) &&
                (ticks_inc >= delay);

    seen_up_mask_next   = seen;
    ticks_waited_next   = ticks_inc;
    held_event_next     = held_event;
    held_key_index_next = held_key_index;
    held_key_state_next = held_key_state;
    repeat_running_next = rr_cur;
    push_n              = 2'd0;
    res0                = '{event_code: ev, key_index: idx, from_repeat: 1'b0, last: 1'b1};
    res1                = '{event_code: partner, key_index: idx, from_repeat: 1'b1,
                            last: 1'b1};

    if ((fresh != '0) && (ev != kea_pkg::EV_NONE)) begin
      held_event_next     = ev;
      held_key_index_next = idx;
      held_key_state_next = ks;
      seen_up_mask_next   = '0;
      ticks_waited_next   = '0;
      if (partner != kea_pkg::EV_NONE) begin
        res0.last = 1'b0;
        push_n    = 2'd2;
      end else begin
        push_n    = 2'd1;
      end
    end else if (do_repeat) begin
      repeat_running_next = 1'b1;
      seen_up_mask_next   = '0;
      ticks_waited_next   = '0;
      res0 = '{event_code: held_event, key_index: held_key_index, from_repeat: 1'b1,
               last: 1'b1};
      push_n = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_up_mask   <= '0;
      ticks_waited   <= '0;
      held_event     <= kea_pkg::EV_NONE;
      held_key_index <= '0;
      held_key_state <= '0;
      repeat_running <= 1'b0;
    end else if (fire) begin
      seen_up_mask   <= seen_up_mask_next;
      ticks_waited   <= ticks_waited_next;
      held_event     <= held_event_next;
      held_key_index <= held_key_index_next;
      held_key_state <= held_key_state_next;
      repeat_running <= repeat_running_next;
    end
  end

  // ---------------------------------------------------------------- result queue
  always_ff @(posedge clk) begin
    if (fire && (push_n != 2'd0)) fifo[wr_ptr] <= res0;
    if (fire && (push_n == 2'd2)) fifo[wr_ptr + 2'd1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (fire) wr_ptr <= wr_ptr + push_n;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + (fire ? {1'b0, push_n} : 3'd0) - {2'b00, pop};
    end
  end

  assign out_valid   = (count != 3'd0);
  assign event_code  = fifo[rd_ptr].event_code;
  assign key_index   = fifo[rd_ptr].key_index;
  assign from_repeat = fifo[rd_ptr].from_repeat;
  assign last        = fifo[rd_ptr].last;

  // ---------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  a_partner_pair: assert property (@(posedge clk) disable iff (rst)
    (fire && (push_n == 2'd2)) |-> (!res0.last && res1.last && res1.from_repeat))
    else $error("closing partner pair malformed");

  a_run_repeatable: assert property (@(posedge clk) disable iff (rst)
    repeat_running |-> kea_pkg::repeatable(held_event))
    else $error("repeat run on a non-repeating event");

  a_fire_room: assert property (@(posedge clk) disable iff (rst)
    (fire && (push_n != 2'd0)) |=> (count != 3'd0))
    else $error("pushed result not visible");

endmodule

FILE: dv/tb_keyboard_event_autorepeat.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyboard_event_autorepeat
// Self-checking bench for the key matrix scan decoder: scan tick requests go
// in, and a scoreboard predicts the key events and their auto-repeats and
// compares every result, field by field, in order.
// ----------------------------------------------------------------------------
module tb_keyboard_event_autorepeat;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the decoder state for each accepted scan tick and
  // queues the events that tick must produce.
  // --------------------------------------------------------------------------
  class autorepeat_scoreboard;
    logic [kea_pkg::DELAY_W-1:0] first_delay;
    logic [kea_pkg::DELAY_W-1:0] next_delay;
    logic [kea_pkg::KEY_W-1:0]   seen_up;
    logic [kea_pkg::DELAY_W-1:0] ticks;
    logic [kea_pkg::EV_W-1:0]    held_ev;
    logic [kea_pkg::IDX_W-1:0]   held_idx;
    logic [kea_pkg::KEY_W-1:0]   held_keys;
    bit                          running;
    kea_pkg::result_t            expected_events[$];
    int                          errors;

    function new();
      first_delay = kea_pkg::FIRST_DELAY_RST;
      next_delay  = kea_pkg::NEXT_DELAY_RST;
      seen_up     = '0;
      ticks       = '0;
      held_ev     = kea_pkg::EV_NONE;
      held_idx    = '0;
      held_keys   = '0;
      running     = 0;
      errors      = 0;
    endfunction

    function void set_delay(logic [kea_pkg::CFG_IDX_W-1:0] idx,
                            logic [kea_pkg::DELAY_W-1:0] val);
      if (idx == kea_pkg::REG_FIRST_DELAY) first_delay = val;
      else if (idx == kea_pkg::REG_NEXT_DELAY) next_delay = val;
    endfunction

    function bit is_typematic(logic [kea_pkg::EV_W-1:0] ev);
      return ev == kea_pkg::EV_LEFT || ev == kea_pkg::EV_UP || ev == kea_pkg::EV_DOWN ||
             ev == kea_pkg::EV_RIGHT || ev == kea_pkg::EV_BACKSPACE;
    endfunction

    function void push_event(logic [kea_pkg::EV_W-1:0] ev, logic [kea_pkg::IDX_W-1:0] idx,
                             bit rep, bit fin);
      kea_pkg::result_t r;
      r.event_code  = ev;
      r.key_index   = idx;
      r.from_repeat = rep;
      r.last        = fin;
      expected_events.push_back(r);
    endfunction

    // one accepted scan tick
    function void note_scan_tick(logic [kea_pkg::KEY_W-1:0] keys, logic sh, logic al);
      logic [kea_pkg::KEY_W-1:0]   ks;
      logic [kea_pkg::KEY_W-1:0]   fresh;
      logic [kea_pkg::EV_W-1:0]    ev;
      logic [kea_pkg::EV_W-1:0]    closing;
      logic [kea_pkg::DELAY_W-1:0] wait_limit;
      int                          i;
      ks      = keys & kea_pkg::KEY_MASK;
      seen_up = (seen_up | ~ks) & kea_pkg::KEY_MASK;
      fresh   = seen_up & ks;
      if (fresh != '0) begin
        running = 0;
        i = 0;
        while (i < kea_pkg::KEY_W - 1 && !fresh[i]) i++;
        ev = kea_pkg::KEYMAP[{al, sh}][i];
        if (ev != kea_pkg::EV_NONE) begin
          held_ev   = ev;
          held_idx  = kea_pkg::IDX_W'(i);
          held_keys = ks;
          seen_up   = '0;
          ticks     = '0;
          case (ev)
            kea_pkg::EV_LPAREN:   closing = kea_pkg::EV_RPAREN;
            kea_pkg::EV_LBRACE:   closing = kea_pkg::EV_RBRACE;
            kea_pkg::EV_LBRACKET: closing = kea_pkg::EV_RBRACKET;
            default:              closing = kea_pkg::EV_NONE;
          endcase
          push_event(ev, kea_pkg::IDX_W'(i), 1'b0, closing == kea_pkg::EV_NONE);
          if (closing != kea_pkg::EV_NONE)
            push_event(closing, kea_pkg::IDX_W'(i), 1'b1, 1'b1);
          return;
        end
      end
      // no fresh event: counter saturates, then the typematic check
      if (ticks != kea_pkg::TICK_MAX) ticks++;
      if (is_typematic(held_ev) && ks == held_keys) begin
        wait_limit = running ? next_delay : first_delay;
        if (ticks >= wait_limit) begin
          running = 1;
          seen_up = '0;
          ticks   = '0;
          push_event(held_ev, held_idx, 1'b1, 1'b1);
        end
      end
    endfunction

    function void check_event(kea_pkg::result_t got);
      kea_pkg::result_t want;
      if (expected_events.size() == 0) begin
        $error("unexpected event: event_code %0d key_index %0d", got.event_code,
               got.key_index);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      if (got.event_code !== want.event_code) begin
        $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
        errors++;
      end
      if (got.key_index !== want.key_index) begin
        $error("key_index: expected %0d, got %0d", want.key_index, got.key_index);
        errors++;
      end
      if (got.from_repeat !== want.from_repeat) begin
        $error("from_repeat: expected %0d, got %0d", want.from_repeat, got.from_repeat);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; everything starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          cfg_write    = 1'b0;
  logic [kea_pkg::CFG_IDX_W-1:0] cfg_index    = kea_pkg::REG_FIRST_DELAY;
  logic [kea_pkg::DELAY_W-1:0]   cfg_data     = '0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic [kea_pkg::KEY_W-1:0]     key_state    = '0;
  logic                          shift_active = 1'b0;
  logic                          alpha_active = 1'b0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic [kea_pkg::EV_W-1:0]      event_code;
  logic [kea_pkg::IDX_W-1:0]     key_index;
  logic                          from_repeat;
  logic                          last;

  // percentage of cycles each side sits idle; changed between phases
  int unsigned          send_idle_pct = 6;
  int unsigned          sink_idle_pct = 56;

  autorepeat_scoreboard sb = new();

  // keys that map to backspace and the four arrows in the plain keymap row
  localparam int TYPEMATIC_KEYS [5] = '{2, 15, 37, 44, 57};

  always #5 clk = ~clk;

  keyboard_event_autorepeat dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_state    (key_state),
    .shift_active (shift_active),
    .alpha_active (alpha_active),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .key_index    (key_index),
    .from_repeat  (from_repeat),
    .last         (last)
  );

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, and every accepted result is checked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_event('{event_code, key_index, from_repeat, last});
    end
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // one scan tick request; optional idle cycles first, then hold until taken
  task automatic send_tick(input logic [kea_pkg::KEY_W-1:0] keys, input logic sh,
                           input logic al);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    key_state    <= keys;
    shift_active <= sh;
    alpha_active <= al;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_scan_tick(keys, sh, al);
  endtask

  // drop the request line, wait for every expected event, then let a tick
  // that produces nothing work its way through the block
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // both delay registers, back to back; only called with the block idle
  task automatic write_delays(input logic [kea_pkg::DELAY_W-1:0] first_val,
                              input logic [kea_pkg::DELAY_W-1:0] next_val);
    cfg_write <= 1'b1;
    cfg_index <= kea_pkg::REG_FIRST_DELAY;
    cfg_data  <= first_val;
    @(posedge clk);
    cfg_index <= kea_pkg::REG_NEXT_DELAY;
    cfg_data  <= next_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_delay(kea_pkg::REG_FIRST_DELAY, first_val);
    sb.set_delay(kea_pkg::REG_NEXT_DELAY, next_val);
  endtask

  // Random typing: mostly press-and-hold episodes (release, press one key or
  // two, hold so the typematic timer gets going), with some stray key words
  // and the odd extra key dropping in or out part-way through a hold.
  task automatic scan_episodes(input int count);
    int                        done;
    int                        hold;
    int                        key;
    logic                      sh;
    logic                      al;
    logic [kea_pkg::KEY_W-1:0] keys;
    logic [kea_pkg::KEY_W-1:0] extra;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 15) begin
        send_tick({$urandom, $urandom}, 1'($urandom_range(1)), 1'($urandom_range(1)));
        done++;
      end else begin
        sh = 1'($urandom_range(1));
        al = 1'($urandom_range(1));
        hold = $urandom_range(1, 3);
        repeat (hold) send_tick('0, sh, al);
        done += hold;
        key  = $urandom_range(1) ? TYPEMATIC_KEYS[$urandom_range(4)] : $urandom_range(63);
        keys = kea_pkg::KEY_W'(1) << key;
        if ($urandom_range(3) == 0) keys |= kea_pkg::KEY_W'(1) << $urandom_range(63);
        hold = $urandom_range(1, 45);
        repeat (hold) send_tick(keys, sh, al);
        done += hold;
        // broken hold: a second key joins, then lets go again
        if ($urandom_range(4) == 0) begin
          extra = kea_pkg::KEY_W'(1) << $urandom_range(63);
          hold  = $urandom_range(1, 6);
          repeat (hold) send_tick(keys | extra, sh, al);
          repeat (hold) send_tick(keys, sh, al);
          done += 2 * hold;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase 0: reset delays, directed ticks first.
    // Plain press, a key with no keymap entry, the three opening brackets
    // (each followed by its closing partner), all keys down in two rows,
    // and presses in the alpha and shift+alpha rows.
    send_tick('0, 1'b0, 1'b0);
    send_tick(kea_pkg::KEY_W'(1) << 1, 1'b0, 1'b0);
    send_tick('0, 1'b0, 1'b0);
    send_tick(kea_pkg::KEY_W'(1) << 63, 1'b0, 1'b0);
    send_tick('0, 1'b0, 1'b0);
    send_tick(kea_pkg::KEY_W'(1) << 60, 1'b0, 1'b0);
    send_tick('0, 1'b0, 1'b0);
    send_tick(kea_pkg::KEY_W'(1) << 38, 1'b1, 1'b0);
    send_tick('0, 1'b1, 1'b0);
    send_tick(kea_pkg::KEY_W'(1) << 14, 1'b1, 1'b0);
    send_tick('0, 1'b0, 1'b0);
    send_tick('1, 1'b0, 1'b0);
    send_tick('0, 1'b1, 1'b1);
    send_tick('1, 1'b1, 1'b1);
    send_tick('0, 1'b0, 1'b1);
    send_tick(kea_pkg::KEY_W'(1) << 3, 1'b0, 1'b1);
    send_tick('0, 1'b1, 1'b1);
    send_tick(kea_pkg::KEY_W'(1) << 52, 1'b1, 1'b1);
    send_tick('0, 1'b0, 1'b0);
    send_tick(kea_pkg::KEY_W'(1) << 62, 1'b0, 1'b0);
    scan_episodes(130);
    drain();

    // Phase 1: shortest non-zero delays
    write_delays(10'd1, 10'd1);
    scan_episodes(130);
    drain();

    // Phase 2: zero delay repeats on every tick; sides swap their idling
    send_idle_pct = 56;
    sink_idle_pct = 6;
    write_delays(10'd0, 10'd0);
    scan_episodes(130);
    drain();

    // Phase 3: short mixed delays
    write_delays(10'd3, 10'd2);
    scan_episodes(130);
    drain();

    // Phase 4: longest delays, no idling
    send_idle_pct = 0;
    sink_idle_pct = 0;
    write_delays(10'd1023, 10'd1023);
    scan_episodes(60);
    drain();

    // Phase 5: long first delay, short repeat
    write_delays(10'd12, 10'd3);
    scan_episodes(150);
    drain();

    if (sb.errors == 0) $display("PASS keyboard_event_autorepeat");
    else $display("FAIL keyboard_event_autorepeat");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL keyboard_event_autorepeat");
    $finish;
  end

endmodule
